// ----- rtl/pslu_pkg.sv -----
`timescale 1ns / 1ps

package pslu_pkg;

    localparam int MAX_NESTING_DEFAULT = 255;
    localparam int QUEUE_DEPTH         = 4;
    localparam int MAX_RESULTS         = 4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LPAREN    = 8'h28;
    localparam logic [7:0] CHAR_RPAREN    = 8'h29;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_SEVEN     = 8'h37;

    typedef enum logic [1:0] {
        KIND_DATA         = 2'd0,
        KIND_CLOSED       = 2'd1,
        KIND_UNTERMINATED = 2'd2
    } kind_t;

    typedef struct packed {
        logic [2:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        kind_t                        final_kind;
    } cmd_t;

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        logic [7:0] v;
        begin
            case (b)
                8'h6E:   v = 8'h0A;
                8'h72:   v = 8'h0D;
                8'h62:   v = 8'h08;
                8'h74:   v = 8'h09;
                8'h66:   v = 8'h0C;
                default: v = b;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] digit_char(input logic [2:0] d);
        return {5'b00110, d};
    endfunction

endpackage

// ----- rtl/pslu_if.sv -----
`timescale 1ns / 1ps

interface pslu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       source_end;

    modport source (output valid, output in_byte, output source_end, input ready);
    modport sink   (input valid, input in_byte, input source_end, output ready);
endinterface

interface pslu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ----- rtl/pslu_front.sv -----
`timescale 1ns / 1ps

module pslu_front
    import pslu_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic [7:0] in_byte,
    input  logic       source_end,
    input  logic       full,
    output logic       push,
    output cmd_t       cmd
);

    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);

    typedef enum logic [1:0] {
        PLAIN     = 2'd0,
        AFTER_BS  = 2'd1,
        ONE_DIGIT = 2'd2,
        TWO_DIGIT = 2'd3
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [5:0]         held_reg, held_next;

    logic       accept;
    logic       octal;
    logic [2:0] digit;
    logic [2:0] d0;
    logic [2:0] d1;

    assign ready  = !full;
    assign accept = valid && ready;
    assign octal  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_SEVEN);
    assign digit  = in_byte[2:0];
    assign d0     = held_reg[2:0];
    assign d1     = held_reg[5:3];
    assign push   = accept && (cmd.count != 3'd0);

    always_comb
    begin
        phase_next     = phase_reg;
        depth_next     = depth_reg;
        held_next      = held_reg;
        cmd.count      = 3'd0;
        cmd.bytes      = '0;
        cmd.final_kind = KIND_DATA;
        if (source_end)
        begin
            cmd.final_kind = KIND_UNTERMINATED;
            case (phase_reg)
                PLAIN:
                begin
                    cmd.count = 3'd1;
                end
                AFTER_BS:
                begin
                    cmd.count    = 3'd2;
                    cmd.bytes[0] = CHAR_BACKSLASH;
                end
                ONE_DIGIT:
                begin
                    cmd.count    = 3'd3;
                    cmd.bytes[0] = CHAR_BACKSLASH;
                    cmd.bytes[1] = digit_char(d0);
                end
                default:
                begin
                    cmd.count    = 3'd4;
                    cmd.bytes[0] = CHAR_BACKSLASH;
                    cmd.bytes[1] = digit_char(d1);
                    cmd.bytes[2] = digit_char(d0);
                end
            endcase
            phase_next = PLAIN;
            depth_next = '0;
            held_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PLAIN:
                begin
                    if (in_byte == CHAR_BACKSLASH)
                    begin
                        phase_next = AFTER_BS;
                    end
                    else if (in_byte == CHAR_RPAREN && depth_reg == '0)
                    begin
                        cmd.count      = 3'd1;
                        cmd.final_kind = KIND_CLOSED;
                        depth_next     = '0;
                        held_next      = '0;
                    end
                    else
                    begin
                        cmd.count    = 3'd1;
                        cmd.bytes[0] = in_byte;
                        if (in_byte == CHAR_LPAREN)
                        begin
                            if (depth_reg < DEPTH_W'(MAX_NESTING))
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        else if (in_byte == CHAR_RPAREN)
                        begin
                            depth_next = depth_reg - 1'b1;
                        end
                    end
                end
                AFTER_BS:
                begin
                    if (octal)
                    begin
                        held_next  = {3'd0, digit};
                        phase_next = ONE_DIGIT;
                    end
                    else
                    begin
                        cmd.count    = 3'd1;
                        cmd.bytes[0] = escape_map(in_byte);
                        phase_next   = PLAIN;
                    end
                end
                ONE_DIGIT:
                begin
                    if (octal)
                    begin
                        held_next  = {d0, digit};
                        phase_next = TWO_DIGIT;
                    end
                    else
                    begin
                        cmd.count    = 3'd3;
                        cmd.bytes[0] = CHAR_BACKSLASH;
                        cmd.bytes[1] = digit_char(d0);
                        cmd.bytes[2] = in_byte;
                        phase_next   = PLAIN;
                        held_next    = '0;
                    end
                end
                default:
                begin
                    if (octal)
                    begin
                        cmd.count    = 3'd1;
                        cmd.bytes[0] = {held_reg[4:0], digit};
                    end
                    else
                    begin
                        cmd.count    = 3'd4;
                        cmd.bytes[0] = CHAR_BACKSLASH;
                        cmd.bytes[1] = digit_char(d1);
                        cmd.bytes[2] = digit_char(d0);
                        cmd.bytes[3] = in_byte;
                    end
                    phase_next = PLAIN;
                    held_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PLAIN;
            depth_reg <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            depth_reg <= depth_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ----- rtl/pslu_queue.sv -----
`timescale 1ns / 1ps

module pslu_queue
    import pslu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/pslu_back.sv -----
`timescale 1ns / 1ps

module pslu_back
    import pslu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  cmd_t       head,
    output logic       pop,
    output logic       valid,
    input  logic       ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last
);

    logic [1:0] idx_reg;
    logic       is_last;
    logic       accept;

    assign valid    = !empty;
    assign accept   = valid && ready;
    assign is_last  = ({1'b0, idx_reg} == head.count - 3'd1);
    assign out_byte = head.bytes[idx_reg];
    assign kind     = is_last ? head.final_kind : KIND_DATA;
    assign last     = is_last;
    assign pop      = accept && is_last;

    // advance through the request's results, one per handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

// ----- rtl/pdf_literal_string_unescape.sv -----
`timescale 1ns / 1ps

// Decodes the body of a PDF literal string, one raw byte per request on raw, into
// decoded bytes and a closing marker on decoded (kind 0 data, 1 closed, 2 input ended).
// Each request yields zero to four results, handed out one per cycle while decoded
// is ready, with last set on the final one. The front stage takes a request every
// cycle while the four-request queue has room; the back stage drains one result per
// cycle while decoded is ready, and a request that yields no results is never queued.
// Nesting depth saturates at MAX_NESTING.
module pdf_literal_string_unescape
    import pslu_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    pslu_in_if.sink     raw,
    pslu_out_if.source  decoded
);

    logic full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic empty;
    cmd_t head;

    pslu_front #(
        .MAX_NESTING (MAX_NESTING)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (raw.valid),
        .ready      (raw.ready),
        .in_byte    (raw.in_byte),
        .source_end (raw.source_end),
        .full       (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    pslu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    pslu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .valid    (decoded.valid),
        .ready    (decoded.ready),
        .out_byte (decoded.out_byte),
        .kind     (decoded.kind),
        .last     (decoded.last)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pslu_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_ITEMS   = 40;
    localparam int STREAM_ITEMS   = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [7:0] ESC_N  = 8'h6E;
    localparam logic [7:0] ESC_R  = 8'h72;
    localparam logic [7:0] ESC_B  = 8'h62;
    localparam logic [7:0] ESC_T  = 8'h74;
    localparam logic [7:0] ESC_F  = 8'h66;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_FF = 8'h0C;

    typedef enum logic [1:0] {
        PH_TEXT       = 2'd0,
        PH_ESCAPE     = 2'd1,
        PH_ONE_DIGIT  = 2'd2,
        PH_TWO_DIGITS = 2'd3
    } esc_phase_t;

    typedef struct {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } decoded_t;

    logic clk;
    logic rst_n;

    pslu_in_if  raw_if ();
    pslu_out_if dec_if ();

    pdf_literal_string_unescape dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_if),
        .decoded (dec_if)
    );

    esc_phase_t esc_phase;
    logic [7:0] nest_depth;
    logic [5:0] octal_held;

    decoded_t   pending_decoded[$];
    decoded_t   step_results[$];

    int         errors;
    int         sent_count;
    int         idle_cycles;
    logic       no_idle;
    logic       hold_req;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [7:0] control_byte_for(input logic [7:0] b);
        case (b)
            ESC_N:   return CTL_LF;
            ESC_R:   return CTL_CR;
            ESC_B:   return CTL_BS;
            ESC_T:   return CTL_HT;
            ESC_F:   return CTL_FF;
            default: return b;
        endcase
    endfunction

    function automatic void add_result(input logic [7:0] b, input kind_t k);
        decoded_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void add_held_escape();
        add_result(CHAR_BACKSLASH, KIND_DATA);
        if (esc_phase == PH_ONE_DIGIT)
        begin
            add_result(CHAR_ZERO | {5'd0, octal_held[2:0]}, KIND_DATA);
        end
        else if (esc_phase == PH_TWO_DIGITS)
        begin
            add_result(CHAR_ZERO | {5'd0, octal_held[5:3]}, KIND_DATA);
            add_result(CHAR_ZERO | {5'd0, octal_held[2:0]}, KIND_DATA);
        end
    endfunction

    function automatic void clear_string_state();
        esc_phase  = PH_TEXT;
        nest_depth = '0;
        octal_held = '0;
    endfunction

    function automatic void predict_decode(input logic [7:0] b, input logic src_end);
        logic       is_octal;
        logic [8:0] octal_value;
        is_octal = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
        step_results.delete();
        if (src_end)
        begin
            if (esc_phase != PH_TEXT)
                add_held_escape();
            add_result(8'h00, KIND_UNTERMINATED);
            clear_string_state();
        end
        else
        begin
            case (esc_phase)
                PH_TEXT:
                begin
                    if (b == CHAR_BACKSLASH)
                    begin
                        esc_phase = PH_ESCAPE;
                    end
                    else if (b == CHAR_RPAREN && nest_depth == 0)
                    begin
                        add_result(8'h00, KIND_CLOSED);
                        clear_string_state();
                    end
                    else
                    begin
                        if (b == CHAR_LPAREN)
                        begin
                            if (nest_depth < MAX_NESTING_DEFAULT)
                                nest_depth = nest_depth + 8'd1;
                        end
                        else if (b == CHAR_RPAREN)
                        begin
                            nest_depth = nest_depth - 8'd1;
                        end
                        add_result(b, KIND_DATA);
                    end
                end
                PH_ESCAPE:
                begin
                    if (is_octal)
                    begin
                        octal_held = {3'd0, b[2:0]};
                        esc_phase  = PH_ONE_DIGIT;
                    end
                    else
                    begin
                        add_result(control_byte_for(b), KIND_DATA);
                        esc_phase = PH_TEXT;
                    end
                end
                PH_ONE_DIGIT:
                begin
                    if (is_octal)
                    begin
                        octal_held = {octal_held[2:0], b[2:0]};
                        esc_phase  = PH_TWO_DIGITS;
                    end
                    else
                    begin
                        add_held_escape();
                        add_result(b, KIND_DATA);
                        esc_phase  = PH_TEXT;
                        octal_held = '0;
                    end
                end
                default:
                begin
                    if (is_octal)
                    begin
                        octal_value = {octal_held, b[2:0]};
                        add_result(octal_value[7:0], KIND_DATA);
                    end
                    else
                    begin
                        add_held_escape();
                        add_result(b, KIND_DATA);
                    end
                    esc_phase  = PH_TEXT;
                    octal_held = '0;
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            pending_decoded.insert(pending_decoded.size(), step_results[i]);
    endfunction

    task automatic send_request(input logic [7:0] b, input logic src_end);
        logic accepted;
        while (!no_idle && $urandom_range(0, 99) < 34)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid      <= 1'b1;
        raw_if.in_byte    <= b;
        raw_if.source_end <= src_end;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = raw_if.ready;
            if (accepted)
                predict_decode(b, src_end);
            @(posedge clk);
        end
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(b, 1'b0);
    endtask

    task automatic send_escape(input logic [7:0] b);
        send_byte(CHAR_BACKSLASH);
        send_byte(b);
    endtask

    function automatic logic [7:0] random_octal();
        return CHAR_ZERO | 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] random_escape_char();
        case ($urandom_range(0, 8))
            0:       return ESC_N;
            1:       return ESC_R;
            2:       return ESC_B;
            3:       return ESC_T;
            4:       return ESC_F;
            5:       return CHAR_LPAREN;
            6:       return CHAR_RPAREN;
            7:       return CHAR_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_sequence();
        int pick;
        int digits;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 45)
        begin
            send_byte(CHAR_LPAREN);
        end
        else if (pick < 52)
        begin
            send_byte(CHAR_RPAREN);
        end
        else if (pick < 67)
        begin
            send_escape(random_escape_char());
        end
        else if (pick < 80)
        begin
            send_byte(CHAR_BACKSLASH);
            repeat (3) send_byte(random_octal());
        end
        else if (pick < 88)
        begin
            digits = $urandom_range(1, 2);
            send_byte(CHAR_BACKSLASH);
            repeat (digits) send_byte(random_octal());
            if ($urandom_range(0, 1) == 0)
                send_byte(random_escape_char());
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 92)
        begin
            send_request(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (pick < 95)
        begin
            digits = $urandom_range(0, 2);
            send_byte(CHAR_BACKSLASH);
            repeat (digits) send_byte(random_octal());
            send_request(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_LPAREN);
        send_byte(CHAR_RPAREN);
        send_escape(ESC_N);
        send_escape(ESC_R);
        send_escape(ESC_B);
        send_escape(ESC_T);
        send_escape(ESC_F);
        send_escape(CHAR_LPAREN);
        send_escape(CHAR_BACKSLASH);
        send_escape(8'h71);
        send_byte(CHAR_BACKSLASH);
        repeat (3) send_byte(CHAR_SEVEN);
        send_byte(CHAR_BACKSLASH);
        send_byte(CHAR_ZERO);
        send_byte(CHAR_RPAREN);
        send_byte(CHAR_BACKSLASH);
        send_byte(8'h31);
        send_byte(8'h32);
        send_byte(CHAR_LPAREN);
        send_byte(CHAR_RPAREN);
        send_byte(CHAR_BACKSLASH);
        send_byte(8'h35);
        send_request(8'hA5, 1'b1);
        send_request(8'h00, 1'b1);
    endtask

    task automatic test_depth_limit();
        repeat (MAX_NESTING_DEFAULT + 1) send_byte(CHAR_LPAREN);
        send_byte(CHAR_RPAREN);
        send_request(8'h00, 1'b1);
    endtask

    task automatic test_random();
        int start_count;
        start_count = sent_count;
        while (sent_count < start_count + RANDOM_ITEMS)
            send_random_sequence();
    endtask

    task automatic test_streaming();
        int start_count;
        start_count = sent_count;
        no_idle = 1'b1;
        while (sent_count < start_count + STREAM_ITEMS)
            send_random_sequence();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40) send_byte(8'($urandom_range(0, 255)));
        send_request(8'h00, 1'b1);
    endtask

    initial
    begin
        dec_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dec_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                dec_if.ready <= no_idle || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    always @(negedge clk)
    begin
        decoded_t exp_res;
        if (rst_n && dec_if.valid && dec_if.ready)
        begin
            if (pending_decoded.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual byte %02h kind %0d last %0d",
                         $time, dec_if.out_byte, dec_if.kind, dec_if.last);
                errors++;
            end
            else
            begin
                exp_res = pending_decoded.pop_front();
                if (dec_if.out_byte !== exp_res.out_byte)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, exp_res.out_byte, dec_if.out_byte);
                    errors++;
                end
                if (dec_if.kind !== exp_res.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d",
                             $time, exp_res.kind, dec_if.kind);
                    errors++;
                end
                if (dec_if.last !== exp_res.last)
                begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, exp_res.last, dec_if.last);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((raw_if.valid && raw_if.ready) || (dec_if.valid && dec_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        sent_count  = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        clear_string_state();
        rst_n             <= 1'b0;
        raw_if.valid      <= 1'b0;
        raw_if.in_byte    <= 8'h00;
        raw_if.source_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_depth_limit();
        test_random();
        test_streaming();
        test_backpressure();
        test_random();

        raw_if.valid <= 1'b0;
        while (pending_decoded.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
